// ===== rtl/mcss_pkg.sv =====
// ----------------------------------------------------------------------------
// mcss_pkg: shared types and constants of the servo slew stepper
// Action codes, register indexes, pulse scaling constants and the
// bundle that passes one step decision down the pulse pipeline.
// ----------------------------------------------------------------------------
package mcss_pkg;

  // Default number of servo channels.
  localparam int CHANNELS_DEF = 12;

  // Field widths.
  localparam int CH_W    = 4;
  localparam int NOW_W   = 32;
  localparam int ANGLE_W = 8;
  localparam int IVL_W   = 16;
  localparam int CNT_W   = 13;
  localparam int REG_W   = 12;

  // Angle and pulse constants.
  localparam logic [ANGLE_W-1:0] MAX_ANGLE  = 8'd180;
  localparam logic [CNT_W-1:0]   FULL_OFF   = 13'd4096;
  localparam logic [REG_W-1:0]   PMIN_RESET = 12'd150;
  localparam logic [REG_W-1:0]   PMAX_RESET = 12'd600;

  // Division by 180 as a multiply by ceil(2^27 / 180) and a shift.
  // Exact for every dividend below 780000; the largest is 180 * 4095.
  localparam int          DIV_SHIFT = 27;
  localparam int          MAG_W     = 20;
  localparam logic [19:0] DIV_K     = 20'd745655;

  // Register indexes of the configuration port.
  localparam logic CFG_PULSE_MIN = 1'b0;
  localparam logic CFG_PULSE_MAX = 1'b1;

  // Result action codes.
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_PULSE = 2'd1,
    ACT_OFF   = 2'd2
  } action_t;

  // One step decision, handed from the channel state to the pulse mapper.
  typedef struct packed {
    logic [CH_W-1:0]    channel;
    action_t            action;
    logic [ANGLE_W-1:0] pos;
    logic               done;
  } step_res_t;

endpackage

// ===== rtl/mcss_step.sv =====
// ----------------------------------------------------------------------------
// mcss_step: input register and per-channel slew state
// Holds position, last step time and moving flag of every channel and
// decides for each beat whether a step is due and which way it goes.
// ----------------------------------------------------------------------------
module mcss_step #(
  parameter int CHANNELS = mcss_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mcss_pkg::CH_W-1:0]     in_channel,
  input  logic [mcss_pkg::NOW_W-1:0]    in_now_ms,
  input  logic [mcss_pkg::ANGLE_W-1:0]  in_target_position,
  input  logic [mcss_pkg::IVL_W-1:0]    in_step_interval_ms,
  input  logic                          in_new_move,
  output logic                          res_valid,
  input  logic                          res_ready,
  output mcss_pkg::step_res_t           res
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Input register.
  logic                         v_r;
  logic [mcss_pkg::CH_W-1:0]    ch_r;
  logic [mcss_pkg::NOW_W-1:0]   now_r;
  logic [mcss_pkg::ANGLE_W-1:0] tgt_r;
  logic [mcss_pkg::IVL_W-1:0]   ivl_r;
  logic                         nm_r;

  // Channel state.
  logic [mcss_pkg::ANGLE_W-1:0] pos_r  [CHANNELS];
  logic [mcss_pkg::NOW_W-1:0]   last_r [CHANNELS];
  logic                         mov_r  [CHANNELS];

  logic                         adv;
  logic [IDX_W+mcss_pkg::CH_W-1:0] ch_wide;
  logic [IDX_W-1:0]             idx;
  logic                         ch_ok;
  logic [mcss_pkg::ANGLE_W-1:0] tgt_sat;
  logic [mcss_pkg::ANGLE_W-1:0] pos_cur;
  logic [mcss_pkg::NOW_W-1:0]   due_time;
  logic                         due;
  logic                         mov_eff;
  logic [mcss_pkg::ANGLE_W-1:0] pos_nxt;
  logic                         mov_nxt;
  mcss_pkg::action_t            act;
  logic                         done;

  assign adv       = v_r && res_ready;
  assign in_ready  = !v_r || res_ready;
  assign res_valid = v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ch_r  <= in_channel;
      now_r <= in_now_ms;
      tgt_r <= in_target_position;
      ivl_r <= in_step_interval_ms;
      nm_r  <= in_new_move;
    end
  end

  // Channel lookup; channels past the last one change nothing.
  assign ch_wide = {{IDX_W{1'b0}}, ch_r};
  assign idx     = ch_wide[IDX_W-1:0];
  assign ch_ok   = (32'(ch_r) < 32'(CHANNELS));
  assign tgt_sat = (tgt_r > mcss_pkg::MAX_ANGLE) ? mcss_pkg::MAX_ANGLE : tgt_r;

  // Step decision: due when the wrapped last time plus interval lies before now.
  always_comb begin
    pos_cur  = ch_ok ? pos_r[idx] : '0;
    due_time = (ch_ok ? last_r[idx] : '0) + mcss_pkg::NOW_W'(ivl_r);
    due      = ch_ok && (due_time < now_r);
    mov_eff  = ch_ok && (mov_r[idx] || nm_r);
    pos_nxt  = pos_cur;
    mov_nxt  = mov_eff;
    act      = mcss_pkg::ACT_NONE;
    done     = 1'b0;
    if (due) begin
      if (pos_cur > tgt_sat) begin
        pos_nxt = pos_cur - 8'd1;
        act     = mcss_pkg::ACT_PULSE;
      end else if (pos_cur < tgt_sat) begin
        pos_nxt = pos_cur + 8'd1;
        act     = mcss_pkg::ACT_PULSE;
      end else begin
        act     = mcss_pkg::ACT_OFF;
        done    = mov_eff;
        mov_nxt = 1'b0;
      end
    end
  end

  // State is written as the beat leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pos_r[i]  <= '0;
        last_r[i] <= '0;
        mov_r[i]  <= 1'b0;
      end
    end else if (adv && ch_ok) begin
      pos_r[idx] <= pos_nxt;
      mov_r[idx] <= mov_nxt;
      if (due) begin
        last_r[idx] <= now_r;
      end
    end
  end

  assign res.channel = ch_r;
  assign res.action  = act;
  assign res.pos     = pos_nxt;
  assign res.done    = done;

endmodule

// ===== rtl/mcss_pulse.sv =====
// ----------------------------------------------------------------------------
// mcss_pulse: angle to PWM off count pipeline
// Three stages: angle times span, scale by 1/180, then offset, select and
// output register. Each stage holds its beat until the next one is free.
// ----------------------------------------------------------------------------
module mcss_pulse (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [mcss_pkg::REG_W-1:0]   pulse_min,
  input  logic [mcss_pkg::REG_W-1:0]   pulse_max,
  input  logic                         res_valid,
  output logic                         res_ready,
  input  mcss_pkg::step_res_t          res,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mcss_pkg::CH_W-1:0]    out_channel,
  output mcss_pkg::action_t            out_action,
  output logic [mcss_pkg::CNT_W-1:0]   out_count,
  output logic                         out_done
);

  localparam int PROD_W = mcss_pkg::MAG_W + 20;

  logic                        span_neg;
  logic [mcss_pkg::REG_W-1:0]  span_abs;

  // Stage a: magnitude of angle times span.
  logic                        a_v_r;
  mcss_pkg::step_res_t         a_res_r;
  logic [mcss_pkg::MAG_W-1:0]  a_mag_r;
  // Stage b: quotient.
  logic                        b_v_r;
  mcss_pkg::step_res_t         b_res_r;
  logic [mcss_pkg::REG_W-1:0]  b_q_r;
  // Stage c: output register.
  logic                        c_v_r;
  logic [mcss_pkg::CH_W-1:0]   c_ch_r;
  mcss_pkg::action_t           c_act_r;
  logic [mcss_pkg::CNT_W-1:0]  c_cnt_r;
  logic                        c_done_r;

  logic                        ready_a;
  logic                        ready_b;
  logic                        ready_c;
  logic [PROD_W-1:0]           q_prod;
  logic signed [14:0]          cnt_s;
  logic [mcss_pkg::CNT_W-1:0]  cnt_sat;
  logic [mcss_pkg::CNT_W-1:0]  cnt_nxt;

  // The span is split into sign and magnitude so the scaling stays unsigned.
  assign span_neg = pulse_max < pulse_min;
  assign span_abs = span_neg ? (pulse_min - pulse_max) : (pulse_max - pulse_min);

  assign ready_c   = !c_v_r || out_ready;
  assign ready_b   = !b_v_r || ready_c;
  assign ready_a   = !a_v_r || ready_b;
  assign res_ready = ready_a;

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (ready_a) a_v_r <= res_valid;
      if (ready_b) b_v_r <= a_v_r;
      if (ready_c) c_v_r <= b_v_r;
    end
  end

  // Stage a: one 8 by 12 multiply.
  always_ff @(posedge clk) begin
    if (ready_a && res_valid) begin
      a_res_r <= res;
      a_mag_r <= mcss_pkg::MAG_W'(res.pos) * mcss_pkg::MAG_W'(span_abs);
    end
  end

  // Stage b: divide by 180 through the reciprocal.
  assign q_prod = PROD_W'(a_mag_r) * PROD_W'(mcss_pkg::DIV_K);

  always_ff @(posedge clk) begin
    if (ready_b && a_v_r) begin
      b_res_r <= a_res_r;
      b_q_r   <= q_prod[mcss_pkg::DIV_SHIFT +: mcss_pkg::REG_W];
    end
  end

  // Stage c: apply the offset, clamp to the 12-bit range and pick the count.
  assign cnt_s = span_neg ? (15'(signed'({1'b0, pulse_min})) - 15'(signed'({1'b0, b_q_r})))
                          : (15'(signed'({1'b0, pulse_min})) + 15'(signed'({1'b0, b_q_r})));

  always_comb begin
    if (cnt_s < 15'sd0) begin
      cnt_sat = '0;
    end else if (cnt_s > 15'sd4095) begin
      cnt_sat = 13'd4095;
    end else begin
      cnt_sat = cnt_s[mcss_pkg::CNT_W-1:0];
    end
    unique case (b_res_r.action)
      mcss_pkg::ACT_PULSE: cnt_nxt = cnt_sat;
      mcss_pkg::ACT_OFF:   cnt_nxt = mcss_pkg::FULL_OFF;
      default:             cnt_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ready_c && b_v_r) begin
      c_ch_r   <= b_res_r.channel;
      c_act_r  <= b_res_r.action;
      c_cnt_r  <= cnt_nxt;
      c_done_r <= b_res_r.done;
    end
  end

  assign out_valid   = c_v_r;
  assign out_channel = c_ch_r;
  assign out_action  = c_act_r;
  assign out_count   = c_cnt_r;
  assign out_done    = c_done_r;

endmodule

// ===== rtl/multi_channel_servo_slew_stepper_core.sv =====
// ----------------------------------------------------------------------------
// multi_channel_servo_slew_stepper_core: servo slew rate limiter
// Steps each servo channel one degree toward its target per interval and
// maps the angle to a PWM off count.
// ----------------------------------------------------------------------------
// Each input beat services one channel and yields exactly one result beat.
// The core takes one beat per clock cycle while the output is not stalled.
// A beat passes the input register, where the channel state is read and
// written back, then the angle-times-span and the 1/180 scaling stages,
// and is then loaded into the output register. A beat for the same channel
// may follow in the very next cycle, since the state update completes in
// the input stage.
// The pulse_min and pulse_max registers are written through the cfg port
// and must only change while the core holds no beat in flight.
module multi_channel_servo_slew_stepper_core #(
  parameter int CHANNELS = mcss_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  // channel[3:0], now_ms[35:4], target_position[43:36],
  // step_interval_ms[59:44], new_move[60], zero[63:61]
  input  logic [63:0] in_tdata,
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_channel[3:0], action[5:4], pulse_off_count[18:6],
  // move_complete[19], zero[23:20]
  output logic [23:0] out_tdata,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [11:0] cfg_wdata
);

  logic [mcss_pkg::REG_W-1:0] pulse_min_r;
  logic [mcss_pkg::REG_W-1:0] pulse_max_r;

  logic                        res_valid;
  logic                        res_ready;
  mcss_pkg::step_res_t         res;
  logic [mcss_pkg::CH_W-1:0]   out_channel;
  mcss_pkg::action_t           out_action;
  logic [mcss_pkg::CNT_W-1:0]  out_count;
  logic                        out_done;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_min_r <= mcss_pkg::PMIN_RESET;
      pulse_max_r <= mcss_pkg::PMAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mcss_pkg::CFG_PULSE_MIN: pulse_min_r <= cfg_wdata;
        mcss_pkg::CFG_PULSE_MAX: pulse_max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Channel state and step decision.
  mcss_step #(
    .CHANNELS(CHANNELS)
  ) u_step (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_tvalid),
    .in_ready            (in_tready),
    .in_channel          (in_tdata[3:0]),
    .in_now_ms           (in_tdata[35:4]),
    .in_target_position  (in_tdata[43:36]),
    .in_step_interval_ms (in_tdata[59:44]),
    .in_new_move         (in_tdata[60]),
    .res_valid           (res_valid),
    .res_ready           (res_ready),
    .res                 (res)
  );

  // Angle to off count pipeline and output register.
  mcss_pulse u_pulse (
    .clk         (clk),
    .rst_n       (rst_n),
    .pulse_min   (pulse_min_r),
    .pulse_max   (pulse_max_r),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_channel (out_channel),
    .out_action  (out_action),
    .out_count   (out_count),
    .out_done    (out_done)
  );

  assign out_tdata = {4'd0, out_done, out_count, out_action, out_channel};

endmodule

// ===== rtl/mcss_checker.sv =====
// ----------------------------------------------------------------------------
// mcss_checker: port-level assertions of the servo slew stepper
// Watches the result stream for consistent action, count and completion
// fields, and for results that are held while stalled.
// ----------------------------------------------------------------------------
module mcss_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // A stalled result beat stays on the bus.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed while stalled");

  // A disabled output always carries the full-off count.
  a_off_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[5:4] == mcss_pkg::ACT_OFF) |->
      (out_tdata[18:6] == mcss_pkg::FULL_OFF))
    else $error("disable result without full-off count");

  // A result without a write carries no count and no completion.
  a_none_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[5:4] == mcss_pkg::ACT_NONE) |->
      (out_tdata[18:6] == 13'd0) && !out_tdata[19])
    else $error("idle result with count or completion");

  // Completion is only reported together with disabling the output.
  a_done_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[19] |-> (out_tdata[5:4] == mcss_pkg::ACT_OFF))
    else $error("completion without disable");

  // A driven pulse never reaches the full-off code.
  a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[5:4] == mcss_pkg::ACT_PULSE) |-> !out_tdata[18])
    else $error("pulse count out of range");

endmodule

bind multi_channel_servo_slew_stepper_core mcss_checker u_mcss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
